/* design/drp_pkg.sv */
// Shared types and constants for the display region point router.
// No dependencies; used by drp_front, drp_queue, drp_back and the top level.
package drp_pkg;

    localparam int POINT_W   = 16;
    localparam int INDEX_W   = 8;
    localparam int SIZE_W    = 14;
    localparam int ID_W      = 3;
    localparam int STATUS_W  = 2;

    // Packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Entry 0 after reset
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 14'd1024;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 14'd768;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        KIND_ROUTE,
        KIND_SET,
        KIND_RANGE
    } kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [POINT_W-1:0]  point_x;
        logic signed [POINT_W-1:0]  point_y;
        logic [INDEX_W-1:0]         entry_index;
        logic signed [POINT_W-1:0]  entry_x;
        logic signed [POINT_W-1:0]  entry_y;
        logic [SIZE_W-1:0]          entry_width;
        logic [SIZE_W-1:0]          entry_height;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic  empty;
        item_t head;
    } head_t;

endpackage

/* design/drp_front.sv */
// Front end: takes input beats, unpacks them and classifies each item.
// Depends on drp_pkg; feeds drp_queue.
module drp_front #(
    parameter int MONITORS = 8
) (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [drp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          queue_full,
    output drp_pkg::push_t                push
);

    drp_pkg::item_t item;

    always_comb begin
        item.point_x      = s_axis_tdata[15:0];
        item.point_y      = s_axis_tdata[31:16];
        item.entry_index  = s_axis_tdata[39:32];
        item.entry_x      = s_axis_tdata[55:40];
        item.entry_y      = s_axis_tdata[71:56];
        item.entry_width  = s_axis_tdata[85:72];
        item.entry_height = s_axis_tdata[99:86];
        if (!s_axis_tuser) begin
            item.kind = drp_pkg::KIND_ROUTE;
        end else if (32'(item.entry_index) < MONITORS) begin
            item.kind = drp_pkg::KIND_SET;
        end else begin
            item.kind = drp_pkg::KIND_RANGE;
        end
    end

    assign s_axis_tready = !queue_full;
    assign push.valid    = s_axis_tvalid && !queue_full;
    assign push.item     = item;

endmodule

/* design/drp_queue.sv */
// Short FIFO of classified items between front and back.
// Depends on drp_pkg.
module drp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  drp_pkg::push_t push,
    output logic           full,
    input  logic           pop,
    output drp_pkg::head_t head
);

    drp_pkg::item_t                     mem [drp_pkg::QUEUE_DEPTH];
    logic [drp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [drp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [drp_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [drp_pkg::QUEUE_CNT_W-1:0]    count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full       = (count_reg == drp_pkg::QUEUE_CNT_W'(drp_pkg::QUEUE_DEPTH));
    assign head.empty = (count_reg == '0);
    assign head.head  = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && !head.empty;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* design/drp_back.sv */
// Back end: monitor table, parallel rectangle cells, priority pick, output register.
// Depends on drp_pkg; pops from drp_queue.
module drp_back #(
    parameter int MONITORS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  drp_pkg::head_t                head,
    output logic                          pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [drp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [drp_pkg::STATUS_W-1:0]  m_axis_tuser
);

    localparam int IDX_W = (MONITORS > 1) ? $clog2(MONITORS) : 1;
    localparam int CMP_W = drp_pkg::POINT_W + 2;

    drp_pkg::back_state_t state_reg, state_next;
    drp_pkg::item_t       work_reg;
    logic [MONITORS-1:0]  hit_reg;
    logic [MONITORS-1:0]  hit_next;

    logic signed [drp_pkg::POINT_W-1:0] offset_x_reg [MONITORS];
    logic signed [drp_pkg::POINT_W-1:0] offset_y_reg [MONITORS];
    logic [drp_pkg::SIZE_W-1:0]         width_reg    [MONITORS];
    logic [drp_pkg::SIZE_W-1:0]         height_reg   [MONITORS];
    logic [MONITORS-1:0]                active_reg;

    logic                               out_valid_reg, out_valid_next;
    logic [drp_pkg::M_TDATA_W-1:0]      out_data_reg;
    logic [drp_pkg::STATUS_W-1:0]       out_user_reg;

    logic                               out_free;
    logic                               load_out;
    logic                               table_we;
    logic [IDX_W-1:0]                   wr_idx;
    logic [IDX_W-1:0]                   sel_idx;
    logic [drp_pkg::POINT_W-1:0]        diff_x;
    logic [drp_pkg::POINT_W-1:0]        diff_y;
    logic [drp_pkg::STATUS_W-1:0]       res_status;
    logic [drp_pkg::ID_W-1:0]           res_id;
    logic [drp_pkg::SIZE_W-1:0]         res_lx;
    logic [drp_pkg::SIZE_W-1:0]         res_ly;

    // Rectangle cells, one per entry; half-open bounds at 18 bits
    always_comb begin
        logic signed [CMP_W-1:0] px, py, lo_x, lo_y, hi_x, hi_y;
        px = CMP_W'(work_reg.point_x);
        py = CMP_W'(work_reg.point_y);
        for (int i = 0; i < MONITORS; i++) begin
            lo_x = CMP_W'(offset_x_reg[i]);
            lo_y = CMP_W'(offset_y_reg[i]);
            hi_x = lo_x + $signed({4'b0, width_reg[i]});
            hi_y = lo_y + $signed({4'b0, height_reg[i]});
            hit_next[i] = active_reg[i] && (px >= lo_x) && (px < hi_x)
                          && (py >= lo_y) && (py < hi_y);
        end
    end

    // Lowest hit index wins
    always_comb begin
        sel_idx = '0;
        for (int i = MONITORS - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin
                sel_idx = IDX_W'(i);
            end
        end
    end

    assign diff_x = work_reg.point_x - offset_x_reg[sel_idx];
    assign diff_y = work_reg.point_y - offset_y_reg[sel_idx];

    always_comb begin
        res_status = drp_pkg::ST_OK;
        res_id     = '0;
        res_lx     = '0;
        res_ly     = '0;
        case (work_reg.kind)
            drp_pkg::KIND_ROUTE: begin
                if (|hit_reg) begin
                    res_id = drp_pkg::ID_W'(sel_idx);
                    res_lx = diff_x[drp_pkg::SIZE_W-1:0];
                    res_ly = diff_y[drp_pkg::SIZE_W-1:0];
                end else begin
                    res_status = drp_pkg::ST_MISS;
                end
            end
            drp_pkg::KIND_SET:   res_status = drp_pkg::ST_OK;
            drp_pkg::KIND_RANGE: res_status = drp_pkg::ST_RANGE;
            default:             res_status = drp_pkg::ST_RANGE;
        endcase
    end

    assign out_free = !out_valid_reg || m_axis_tready;
    assign wr_idx   = work_reg.entry_index[IDX_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            drp_pkg::BK_IDLE:  if (!head.empty) state_next = drp_pkg::BK_MATCH;
            drp_pkg::BK_MATCH: state_next = drp_pkg::BK_EMIT;
            drp_pkg::BK_EMIT:  if (out_free) state_next = drp_pkg::BK_IDLE;
            default:           state_next = drp_pkg::BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        pop      = 1'b0;
        table_we = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            drp_pkg::BK_IDLE:  pop      = !head.empty;
            drp_pkg::BK_MATCH: table_we = (work_reg.kind == drp_pkg::KIND_SET);
            drp_pkg::BK_EMIT:  load_out = out_free;
            default:           pop      = 1'b0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= drp_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            work_reg <= head.head;
        end
        if (state_reg == drp_pkg::BK_MATCH) begin
            hit_reg <= hit_next;
        end
        if (load_out) begin
            out_user_reg <= res_status;
            out_data_reg <= {1'b0, res_ly, res_lx, res_id};
        end
    end

    // Monitor table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MONITORS; i++) begin
                offset_x_reg[i] <= '0;
                offset_y_reg[i] <= '0;
                width_reg[i]    <= '0;
                height_reg[i]   <= '0;
            end
            width_reg[0]  <= drp_pkg::RESET_WIDTH;
            height_reg[0] <= drp_pkg::RESET_HEIGHT;
            active_reg    <= MONITORS'(1);
        end else if (table_we) begin
            offset_x_reg[wr_idx] <= work_reg.entry_x;
            offset_y_reg[wr_idx] <= work_reg.entry_y;
            width_reg[wr_idx]    <= work_reg.entry_width;
            height_reg[wr_idx]   <= work_reg.entry_height;
            active_reg[wr_idx]   <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

/* design/display_region_point_router.sv */
// Top level of the display region point router.
// Depends on drp_pkg, drp_front, drp_queue and drp_back.
//
// Keeps a table of MONITORS monitor rectangles (signed offset, unsigned size,
// active mark). A route beat (tuser 0) returns the first active entry, lowest
// index first, whose half-open rectangle holds the point, with the point in
// that monitor's local coordinates; status 1 if none holds it. A set beat
// (tuser 1) overwrites one entry and marks it active; an index at or above
// MONITORS leaves the table alone and returns status 2. After reset, entry 0
// is 1024x768 at the origin and the rest are inactive. Every input beat gives
// exactly one output beat, in order. The front end classifies beats into a
// 4-deep queue and takes new beats whenever that queue has room; the back end
// takes each item through BK_IDLE (pop), BK_MATCH (parallel rectangle compare)
// and BK_EMIT (priority pick and local subtract into the output register), and
// pops the next item only once the last is loaded. The output register holds a
// result while m_axis_tready is low; new beats still enter the queue until full.
module display_region_point_router #(
    parameter int MONITORS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x[15:0] point_y[31:16] entry_index[39:32] entry_x[55:40]
    // entry_y[71:56] entry_width[85:72] entry_height[99:86], zero pad to 104
    input  logic [103:0] s_axis_tdata,
    // action[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // entry_id[2:0] local_x[16:3] local_y[30:17], zero pad to 32
    output logic [31:0]  m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser
);

    drp_pkg::push_t push;
    drp_pkg::head_t head;
    logic           queue_full;
    logic           pop;

    drp_front #(
        .MONITORS (MONITORS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push)
    );

    drp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (queue_full),
        .pop     (pop),
        .head    (head)
    );

    drp_back #(
        .MONITORS (MONITORS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
